>>> rtl/slfb_pkg.sv
package slfb_pkg;

    localparam int unsigned MAX_WIDTH = 4096;

    localparam int COL_W   = 12;
    localparam int LW_W    = 13;
    localparam int PIX_W   = 8;
    localparam int NUM_W   = LW_W + PIX_W;
    localparam int NCHAN   = 3;
    localparam int CFG_W   = LW_W;

    typedef enum logic [0:0] {
        REG_OVERLAP_START = 1'b0,
        REG_LEFT_WIDTH    = 1'b1
    } reg_idx_t;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [NCHAN-1:0][PIX_W-1:0] rgb_t;

    // one restoring-division step: returns {remainder, shifted numerator/quotient}
    function automatic logic [LW_W+PIX_W-1:0] div_step(
        input logic [LW_W-1:0]  rem,
        input logic [PIX_W-1:0] nq,
        input logic [LW_W-1:0]  w
    );
        logic [LW_W:0]   t;
        logic [LW_W:0]   d;
        logic [LW_W-1:0] r;
        logic [PIX_W-1:0] q;
        t = {rem, nq[PIX_W-1]};
        d = t - {1'b0, w};
        if (t >= {1'b0, w})
        begin
            r = d[LW_W-1:0];
            q = {nq[PIX_W-2:0], 1'b1};
        end
        else
        begin
            r = t[LW_W-1:0];
            q = {nq[PIX_W-2:0], 1'b0};
        end
        return {r, q};
    endfunction

endpackage

>>> rtl/slfb_in_if.sv
interface slfb_in_if;
    import slfb_pkg::*;

    logic               valid;
    logic               ready;
    logic [COL_W-1:0]   column;
    logic [PIX_W-1:0]   left_red;
    logic [PIX_W-1:0]   left_green;
    logic [PIX_W-1:0]   left_blue;
    logic [PIX_W-1:0]   warped_red;
    logic [PIX_W-1:0]   warped_green;
    logic [PIX_W-1:0]   warped_blue;

    modport source (
        output valid, column, left_red, left_green, left_blue,
               warped_red, warped_green, warped_blue,
        input  ready
    );

    modport sink (
        input  valid, column, left_red, left_green, left_blue,
               warped_red, warped_green, warped_blue,
        output ready
    );
endinterface

>>> rtl/slfb_out_if.sv
interface slfb_out_if;
    import slfb_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   blend_red;
    logic [PIX_W-1:0]   blend_green;
    logic [PIX_W-1:0]   blend_blue;
    logic               in_overlap;

    modport source (
        output valid, blend_red, blend_green, blend_blue, in_overlap,
        input  ready
    );

    modport sink (
        input  valid, blend_red, blend_green, blend_blue, in_overlap,
        output ready
    );
endinterface

>>> rtl/seam_linear_feather_blend.sv
// Channel  | Role | Carries
// ---------+------+----------------------------------------------------------
// in_ch    | sink | column, left_red/green/blue, warped_red/green/blue
// out_ch   | src  | blend_red/green/blue, in_overlap
// cfg      | in   | cfg_we, cfg_index, cfg_data (overlap_start, left_width)
//
// Six-stage pipeline: decode, multiply-add, four divider stages (two quotient
// bits each). One transfer per cycle sustained while out_ch.ready stays high.
// rst_n clears valid bits and the config registers; data registers are not reset.
// Each stage holds only while it is full and the stage after it is blocked, so
// bubbles are squeezed out and a stall loses nothing.
module seam_linear_feather_blend (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  slfb_pkg::reg_idx_t         cfg_index,
    input  logic [slfb_pkg::CFG_W-1:0] cfg_data,
    slfb_in_if.sink                    in_ch,
    slfb_out_if.source                 out_ch
);
    import slfb_pkg::*;

    localparam int NSTG    = 6;
    localparam int NDIV    = 5;
    localparam logic [LW_W-1:0] LW_CAP   = LW_W'(MAX_WIDTH);
    localparam logic [LW_W-1:0] LW_RESET = LW_W'(4096);

    typedef struct packed {
        logic                           pass;
        logic                           ov;
        rgb_t                           pix;
        rgb_t                           lp;
        rgb_t                           wp;
        logic [LW_W-1:0]                w;
        logic [LW_W-1:0]                wk;
        logic [COL_W-1:0]               k;
    } dec_t;

    typedef struct packed {
        logic                           pass;
        logic                           ov;
        rgb_t                           pix;
        logic [LW_W-1:0]                w;
        logic [NCHAN-1:0][LW_W-1:0]     rem;
        logic [NCHAN-1:0][PIX_W-1:0]    nq;
    } div_t;

    logic [COL_W-1:0] overlap_start_reg;
    logic [LW_W-1:0]  left_width_reg;
    logic [LW_W-1:0]  lw_eff;

    logic [NSTG-1:0]  v_reg;
    logic [NSTG-1:0]  adv;

    dec_t             dec_reg;
    dec_t             dec_next;
    div_t             dv_reg  [NDIV];
    div_t             dv_next [NDIV];

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overlap_start_reg <= '0;
            left_width_reg    <= LW_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OVERLAP_START: overlap_start_reg <= cfg_data[COL_W-1:0];
                REG_LEFT_WIDTH:    left_width_reg    <= cfg_data[LW_W-1:0];
                default: ;
            endcase
        end
    end

    assign lw_eff = (32'(left_width_reg) > MAX_WIDTH) ? LW_CAP : left_width_reg;

    // stage advance chain
    always_comb
    begin
        adv[NSTG-1] = !v_reg[NSTG-1] || out_ch.ready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
    end

    assign in_ch.ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= in_ch.valid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (adv[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // stage 1: region decode
    always_comb
    begin
        logic ge_lw;
        logic lt_os;
        logic black;
        ge_lw = {1'b0, in_ch.column} >= lw_eff;
        lt_os = in_ch.column < overlap_start_reg;
        black = ~|{in_ch.warped_red, in_ch.warped_green, in_ch.warped_blue};
        dec_next.lp  = {in_ch.left_blue, in_ch.left_green, in_ch.left_red};
        dec_next.wp  = {in_ch.warped_blue, in_ch.warped_green, in_ch.warped_red};
        dec_next.ov  = !ge_lw && !lt_os;
        dec_next.pass = ge_lw || lt_os || black;
        dec_next.pix = ge_lw ? dec_next.wp : dec_next.lp;
        dec_next.w   = lw_eff - {1'b0, overlap_start_reg};
        dec_next.k   = in_ch.column - overlap_start_reg;
        dec_next.wk  = dec_next.w - {1'b0, dec_next.k};
    end

    // stage 2: weighted sum, loaded as remainder and numerator low bits
    // stages 3..6: two quotient bits per stage
    always_comb
    begin
        logic [NUM_W-1:0]      num;
        logic [LW_W+PIX_W-1:0] s;
        dv_next[0].pass = dec_reg.pass;
        dv_next[0].ov   = dec_reg.ov;
        dv_next[0].pix  = dec_reg.pix;
        dv_next[0].w    = dec_reg.w;
        for (int c = 0; c < NCHAN; c++)
        begin
            num = NUM_W'(dec_reg.lp[c]) * NUM_W'(dec_reg.wk)
                + NUM_W'(dec_reg.wp[c]) * NUM_W'(dec_reg.k);
            dv_next[0].rem[c] = num[NUM_W-1:PIX_W];
            dv_next[0].nq[c]  = num[PIX_W-1:0];
        end
        for (int j = 1; j < NDIV; j++)
        begin
            dv_next[j] = dv_reg[j-1];
            for (int c = 0; c < NCHAN; c++)
            begin
                s = div_step(dv_reg[j-1].rem[c], dv_reg[j-1].nq[c], dv_reg[j-1].w);
                s = div_step(s[LW_W+PIX_W-1:PIX_W], s[PIX_W-1:0], dv_reg[j-1].w);
                dv_next[j].rem[c] = s[LW_W+PIX_W-1:PIX_W];
                dv_next[j].nq[c]  = s[PIX_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            dec_reg <= dec_next;
        end
        for (int j = 0; j < NDIV; j++)
        begin
            if (adv[j+1])
            begin
                dv_reg[j] <= dv_next[j];
            end
        end
    end

    assign out_ch.valid       = v_reg[NSTG-1];
    assign out_ch.in_overlap  = dv_reg[NDIV-1].ov;
    assign out_ch.blend_red   = dv_reg[NDIV-1].pass ? dv_reg[NDIV-1].pix[0]
                                                    : dv_reg[NDIV-1].nq[0];
    assign out_ch.blend_green = dv_reg[NDIV-1].pass ? dv_reg[NDIV-1].pix[1]
                                                    : dv_reg[NDIV-1].nq[1];
    assign out_ch.blend_blue  = dv_reg[NDIV-1].pass ? dv_reg[NDIV-1].pix[2]
                                                    : dv_reg[NDIV-1].nq[2];

endmodule

>>> tb/seam_linear_feather_blend_test.sv
`timescale 1ns / 1ps
module seam_linear_feather_blend_test;
    import slfb_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int PHASE_ITEMS    = 85;
    localparam int NUM_FIXED      = 10;
    localparam int NUM_RANDOM     = 4;

    localparam logic [CFG_W-1:0] FIXED_OS[NUM_FIXED] =
        '{13'd0, 13'd0, 13'd4095, 13'd0, 13'h1025, 13'd500, 13'd2000, 13'd1, 13'd4095, 13'd16};
    localparam logic [CFG_W-1:0] FIXED_LW[NUM_FIXED] =
        '{13'd4096, 13'd1, 13'd4096, 13'd8191, 13'd4097, 13'd100, 13'd2000, 13'd2, 13'd8191,
          13'd4000};

    typedef struct packed {
        logic [COL_W-1:0] column;
        rgb_t             left;
        rgb_t             warped;
    } pixel_pair_t;

    typedef struct packed {
        rgb_t blend;
        logic in_overlap;
    } blend_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    reg_idx_t         cfg_index;
    logic [CFG_W-1:0] cfg_data;

    slfb_in_if  in_ch();
    slfb_out_if out_ch();

    seam_linear_feather_blend u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    int unsigned overlap_start_q;
    int unsigned left_width_q;
    pixel_pair_t pending_px[$];
    blend_t      expected_px[$];
    int          errors = 0;
    int          idle_cycles = 0;
    int          in_gap = 0;
    int          out_gap = 0;
    bit          burst;
    logic        in_took = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic blend_t feather_pixel(pixel_pair_t p);
        blend_t      r;
        int unsigned lw;
        int unsigned w;
        int unsigned k;
        int unsigned col;
        lw = (left_width_q > MAX_WIDTH) ? MAX_WIDTH : left_width_q;
        col = 32'(p.column);
        r.in_overlap = 1'b0;
        if (col >= lw)
        begin
            r.blend = p.warped;
        end
        else if (col < overlap_start_q)
        begin
            r.blend = p.left;
        end
        else
        begin
            w = lw - overlap_start_q;
            k = col - overlap_start_q;
            r.in_overlap = 1'b1;
            if (p.warped == '0)
            begin
                r.blend = p.left;
            end
            else
            begin
                for (int c = 0; c < NCHAN; c++)
                begin
                    r.blend[c] = pix_t'((p.left[c] * (w - k) + p.warped[c] * k) / w);
                end
            end
        end
        return r;
    endfunction

    function automatic rgb_t rgb(pix_t red, pix_t green, pix_t blue);
        return {blue, green, red};
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic pix_t random_chan();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 8'h00;
        else if (r == 1)
            return 8'hff;
        return pix_t'($urandom);
    endfunction

    function automatic pixel_pair_t random_pair();
        pixel_pair_t p;
        int unsigned lw;
        int unsigned sel;
        int          e;
        lw = (left_width_q > MAX_WIDTH) ? MAX_WIDTH : left_width_q;
        sel = $urandom_range(0, 9);
        if (sel < 6 && overlap_start_q < lw)
        begin
            p.column = COL_W'($urandom_range(overlap_start_q, lw - 1));
        end
        else if (sel < 9)
        begin
            e = $urandom_range(0, 1) ? int'(overlap_start_q) : int'(lw);
            e = e + int'($urandom_range(0, 4)) - 2;
            if (e < 0)
                e = 0;
            if (e > 4095)
                e = 4095;
            p.column = COL_W'(e);
        end
        else
        begin
            p.column = COL_W'($urandom);
        end
        for (int c = 0; c < NCHAN; c++)
        begin
            p.left[c] = random_chan();
            p.warped[c] = random_chan();
        end
        if ($urandom_range(0, 7) == 0)
            p.warped = '0;
        return p;
    endfunction

    function automatic bit pipeline_busy();
        return pending_px.size() != 0 || expected_px.size() != 0 || in_ch.valid === 1'b1;
    endfunction

    task automatic report(string msg);
        errors++;
        if (errors <= 100)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic queue_pixel(logic [COL_W-1:0] col, rgb_t left, rgb_t warped);
        pixel_pair_t p;
        p.column = col;
        p.left = left;
        p.warped = warped;
        pending_px.insert(pending_px.size(), p);
    endtask

    task automatic drain();
        while (pipeline_busy())
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_OVERLAP_START)
            overlap_start_q = 32'(value[COL_W-1:0]);
        else
            left_width_q = 32'(value);
    endtask

    task automatic set_blend_window(logic [CFG_W-1:0] os_raw, logic [CFG_W-1:0] lw_raw);
        drain();
        write_reg(REG_OVERLAP_START, os_raw);
        write_reg(REG_LEFT_WIDTH, lw_raw);
    endtask

    // driver and output stall, both change on the falling edge
    always @(negedge clk)
    begin
        logic        next_valid;
        logic        next_ready;
        logic        load;
        pixel_pair_t next_px;
        next_valid = in_ch.valid;
        load = 1'b0;
        next_px = '0;
        if (!rst_n)
        begin
            next_valid = 1'b0;
            load = 1'b1;
        end
        else if (!in_ch.valid || in_took)
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                next_valid = 1'b0;
            end
            else if (pending_px.size() > 0)
            begin
                next_px = pending_px.pop_front();
                next_valid = 1'b1;
                load = 1'b1;
                in_gap = burst ? 0 : pick_gap();
            end
            else
            begin
                next_valid = 1'b0;
            end
        end
        in_ch.valid <= next_valid;
        if (load)
        begin
            in_ch.column <= next_px.column;
            in_ch.left_red <= next_px.left[0];
            in_ch.left_green <= next_px.left[1];
            in_ch.left_blue <= next_px.left[2];
            in_ch.warped_red <= next_px.warped[0];
            in_ch.warped_green <= next_px.warped[1];
            in_ch.warped_blue <= next_px.warped[2];
        end

        if (out_gap > 0)
        begin
            out_gap--;
            next_ready = 1'b0;
        end
        else
        begin
            next_ready = 1'b1;
            if (!burst && $urandom_range(0, 4) == 0)
                out_gap = pick_gap() + 1;
        end
        out_ch.ready <= next_ready;
    end

    // monitor: transfers are taken at the rising edge
    always @(posedge clk)
    begin
        pixel_pair_t p;
        blend_t      got;
        blend_t      want;
        bit          moved;
        string       chan_name[NCHAN];
        chan_name = '{"red", "green", "blue"};
        moved = 1'b0;
        if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        begin
            p.column = in_ch.column;
            p.left = rgb(in_ch.left_red, in_ch.left_green, in_ch.left_blue);
            p.warped = rgb(in_ch.warped_red, in_ch.warped_green, in_ch.warped_blue);
            expected_px.insert(expected_px.size(), feather_pixel(p));
            moved = 1'b1;
        end
        in_took <= (in_ch.valid === 1'b1 && in_ch.ready === 1'b1);

        if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            moved = 1'b1;
            got.blend = rgb(out_ch.blend_red, out_ch.blend_green, out_ch.blend_blue);
            got.in_overlap = out_ch.in_overlap;
            if (expected_px.size() == 0)
            begin
                report("result transfer with nothing expected");
            end
            else
            begin
                want = expected_px.pop_front();
                for (int c = 0; c < NCHAN; c++)
                begin
                    if (got.blend[c] !== want.blend[c])
                        report($sformatf("blend_%s got %0d expected %0d", chan_name[c],
                                         got.blend[c], want.blend[c]));
                end
                if (got.in_overlap !== want.in_overlap)
                    report($sformatf("in_overlap got %0b expected %0b", got.in_overlap,
                                     want.in_overlap));
            end
        end

        if (moved)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        logic [CFG_W-1:0] os_raw;
        logic [CFG_W-1:0] lw_raw;
        int               phase;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_OVERLAP_START;
        cfg_data = '0;
        burst = 1'b0;
        overlap_start_q = 0;
        left_width_q = 4096;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset window: whole row is overlap, W = 4096
        queue_pixel(12'd0, rgb(8'hff, 8'hff, 8'hff), rgb(8'h01, 8'h02, 8'h03));
        queue_pixel(12'd4095, rgb(8'h00, 8'h00, 8'h00), rgb(8'hff, 8'hff, 8'hff));
        queue_pixel(12'd4095, rgb(8'hff, 8'hff, 8'hff), rgb(8'hff, 8'hff, 8'hff));
        queue_pixel(12'd2048, rgb(8'h80, 8'h10, 8'hff), rgb(8'h7f, 8'hef, 8'h00));
        queue_pixel(12'd1000, rgb(8'h12, 8'h34, 8'h56), rgb(8'h00, 8'h00, 8'h00));
        queue_pixel(12'haaa, rgb(8'haa, 8'h55, 8'hf0), rgb(8'h55, 8'haa, 8'h0f));
        queue_pixel(12'h555, rgb(8'h0f, 8'hf0, 8'h55), rgb(8'hf0, 8'h0f, 8'haa));

        set_blend_window(13'd100, 13'd200);
        queue_pixel(12'd0, rgb(8'h11, 8'h22, 8'h33), rgb(8'h44, 8'h55, 8'h66));
        queue_pixel(12'd99, rgb(8'hff, 8'h00, 8'hff), rgb(8'h00, 8'hff, 8'h00));
        queue_pixel(12'd100, rgb(8'hff, 8'h00, 8'hff), rgb(8'h00, 8'hff, 8'h00));
        queue_pixel(12'd150, rgb(8'h9a, 8'hbc, 8'hde), rgb(8'h00, 8'h00, 8'h00));
        queue_pixel(12'd199, rgb(8'h00, 8'hff, 8'h80), rgb(8'hff, 8'h00, 8'h80));
        queue_pixel(12'd200, rgb(8'h00, 8'hff, 8'h80), rgb(8'hff, 8'h00, 8'h81));
        queue_pixel(12'd4095, rgb(8'h01, 8'h01, 8'h01), rgb(8'hfe, 8'hfe, 8'hfe));

        // left width zero: everything is warped
        set_blend_window(13'd0, 13'd0);
        queue_pixel(12'd0, rgb(8'hff, 8'hff, 8'hff), rgb(8'h00, 8'h00, 8'h00));
        queue_pixel(12'd7, rgb(8'hff, 8'hff, 8'hff), rgb(8'h01, 8'h00, 8'h00));

        // empty overlap
        set_blend_window(13'd300, 13'd300);
        queue_pixel(12'd299, rgb(8'h10, 8'h20, 8'h30), rgb(8'h40, 8'h50, 8'h60));
        queue_pixel(12'd300, rgb(8'h10, 8'h20, 8'h30), rgb(8'h40, 8'h50, 8'h60));

        // left width saturates to MAX_WIDTH, one-column overlap
        set_blend_window(13'd4095, 13'd8191);
        queue_pixel(12'd4095, rgb(8'hc3, 8'h3c, 8'h99), rgb(8'h3c, 8'hc3, 8'h66));
        queue_pixel(12'd4094, rgb(8'hc3, 8'h3c, 8'h99), rgb(8'h3c, 8'hc3, 8'h66));
        queue_pixel(12'd4095, rgb(8'hc3, 8'h3c, 8'h99), rgb(8'h00, 8'h00, 8'h00));

        for (phase = 0; phase < NUM_FIXED + NUM_RANDOM; phase++)
        begin
            if (phase < NUM_FIXED)
            begin
                os_raw = FIXED_OS[phase];
                lw_raw = FIXED_LW[phase];
            end
            else if (phase == NUM_FIXED + NUM_RANDOM - 1)
            begin
                os_raw = CFG_W'($urandom);
                lw_raw = CFG_W'($urandom);
            end
            else
            begin
                os_raw = CFG_W'($urandom_range(0, 4000));
                lw_raw = os_raw + CFG_W'($urandom_range(1, 96));
            end
            set_blend_window(os_raw, lw_raw);
            burst = (phase % 4 == 3);
            repeat (PHASE_ITEMS) pending_px.insert(pending_px.size(), random_pair());
        end

        drain();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
rtl/slfb_pkg.sv
rtl/slfb_in_if.sv
rtl/slfb_out_if.sv
rtl/seam_linear_feather_blend.sv
tb/seam_linear_feather_blend_test.sv
